@@ hw/rtl/tpc_pkg.sv @@
// Shared types, widths and codes for the threshold pixel compactor.
package tpc_pkg;

    localparam int COORD_BITS      = 12;
    localparam int SLOT_BITS       = 16;
    localparam int SLOT_FIELD_BITS = 16;
    localparam int LEVEL_BITS      = 16;
    localparam int FLOW_BITS       = 16;
    localparam int COUNT_BITS      = 17;
    localparam int SCOORD_BITS     = 13;
    localparam int DIM_BITS        = 13;
    localparam int MODE_BITS       = 2;
    localparam int CFG_ADDR_BITS   = 3;
    localparam int CFG_DATA_BITS   = 17;
    localparam int QUEUE_DEPTH     = 4;
    localparam int QUEUE_IDX_BITS  = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_BITS  = $clog2(QUEUE_DEPTH + 1);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    localparam logic KIND_ENTRY = 1'b0;
    localparam logic KIND_COUNT = 1'b1;

    localparam logic [LEVEL_BITS-1:0] THRESHOLD_RESET    = 16'd32768;
    localparam logic [COUNT_BITS-1:0] MAX_ENTRIES_RESET  = 17'd65536;
    localparam logic [DIM_BITS-1:0]   IMAGE_WIDTH_RESET  = 13'd1024;
    localparam logic [DIM_BITS-1:0]   IMAGE_HEIGHT_RESET = 13'd1024;

    typedef enum logic [MODE_BITS-1:0] {
        MODE_RAW      = 2'd0,
        MODE_CENTRED  = 2'd1,
        MODE_FLOW     = 2'd2,
        MODE_HOUGH    = 2'd3
    } mode_t;

    typedef enum logic [CFG_ADDR_BITS-1:0] {
        REG_MODE         = 3'd0,
        REG_THRESHOLD    = 3'd1,
        REG_MAX_ENTRIES  = 3'd2,
        REG_IMAGE_WIDTH  = 3'd3,
        REG_IMAGE_HEIGHT = 3'd4
    } reg_index_t;

    typedef struct packed {
        mode_t                  mode;
        logic [LEVEL_BITS-1:0]  threshold;
        logic [COUNT_BITS-1:0]  max_entries;
        logic [DIM_BITS-1:0]    image_width;
        logic [DIM_BITS-1:0]    image_height;
    } cfg_t;

    typedef struct packed {
        logic                        rec;
        logic                        rep;
        logic [SLOT_FIELD_BITS-1:0]  slot;
        logic [COUNT_BITS-1:0]       total;
        logic [COORD_BITS-1:0]       x;
        logic [COORD_BITS-1:0]       y;
        logic [LEVEL_BITS-1:0]       level;
        logic [FLOW_BITS-1:0]        flow_u;
        logic [FLOW_BITS-1:0]        flow_v;
    } cmd_t;

endpackage

@@ hw/rtl/tpc_front.sv @@
// Front end: accept pixels, test against the threshold, count and queue work.
module tpc_front (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [tpc_pkg::COORD_BITS-1:0]       s_pixel_x,
    input  logic [tpc_pkg::COORD_BITS-1:0]       s_pixel_y,
    input  logic [tpc_pkg::LEVEL_BITS-1:0]       s_level,
    input  logic signed [tpc_pkg::FLOW_BITS-1:0] s_flow_u,
    input  logic signed [tpc_pkg::FLOW_BITS-1:0] s_flow_v,
    input  logic                                 s_frame_end,
    input  tpc_pkg::cfg_t                        cfg,
    input  logic                                 q_full,
    output logic                                 q_wr,
    output tpc_pkg::cmd_t                        q_wdata
);

    logic [tpc_pkg::COUNT_BITS-1:0] pass_count_reg;
    logic [tpc_pkg::COUNT_BITS-1:0] pass_count_next;
    logic [tpc_pkg::COUNT_BITS-1:0] count_inc;
    logic [tpc_pkg::COUNT_BITS-1:0] count_after;
    logic [tpc_pkg::COUNT_BITS-1:0] total;
    logic                           accept;
    logic                           pass;
    logic                           slot_ok;
    logic                           emit_rec;

    assign s_ready  = !q_full;
    assign accept   = s_valid && s_ready;
    assign pass     = s_level >= cfg.threshold;
    assign slot_ok  = (pass_count_reg < cfg.max_entries)
                   && ((pass_count_reg >> tpc_pkg::SLOT_BITS) == '0);
    assign emit_rec = pass && slot_ok;

    always_comb begin
        if (pass_count_reg == tpc_pkg::COUNT_MAX) begin
            count_inc = pass_count_reg;
        end else begin
            count_inc = pass_count_reg + 1'b1;
        end
        count_after = pass ? count_inc : pass_count_reg;
        total = (count_after < cfg.max_entries) ? count_after : cfg.max_entries;
        pass_count_next = pass_count_reg;
        if (accept) begin
            pass_count_next = s_frame_end ? '0 : count_after;
        end
    end

    assign q_wr = accept && (emit_rec || s_frame_end);

    always_comb begin
        q_wdata.rec    = emit_rec;
        q_wdata.rep    = s_frame_end;
        q_wdata.slot   = pass_count_reg[tpc_pkg::SLOT_FIELD_BITS-1:0];
        q_wdata.total  = total;
        q_wdata.x      = s_pixel_x;
        q_wdata.y      = s_pixel_y;
        q_wdata.level  = s_level;
        q_wdata.flow_u = s_flow_u;
        q_wdata.flow_v = s_flow_v;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pass_count_reg <= '0;
        end else begin
            pass_count_reg <= pass_count_next;
        end
    end

endmodule

@@ hw/rtl/tpc_queue.sv @@
// Short command queue between the front and back ends.
module tpc_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          wr,
    input  tpc_pkg::cmd_t wdata,
    output logic          full,
    input  logic          rd,
    output logic          rvalid,
    output tpc_pkg::cmd_t rdata
);

    tpc_pkg::cmd_t                       entries [tpc_pkg::QUEUE_DEPTH];
    logic [tpc_pkg::QUEUE_IDX_BITS-1:0]  wr_ptr_reg;
    logic [tpc_pkg::QUEUE_IDX_BITS-1:0]  rd_ptr_reg;
    logic [tpc_pkg::QUEUE_CNT_BITS-1:0]  count_reg;
    logic [tpc_pkg::QUEUE_CNT_BITS-1:0]  count_next;

    assign full   = count_reg == tpc_pkg::QUEUE_CNT_BITS'(tpc_pkg::QUEUE_DEPTH);
    assign rvalid = count_reg != '0;
    assign rdata  = entries[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (wr && !rd) begin
            count_next = count_reg + 1'b1;
        end else if (!wr && rd) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr) begin
            entries[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (wr) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (rd) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= tpc_pkg::QUEUE_CNT_BITS'(tpc_pkg::QUEUE_DEPTH))
        else $error("queue count beyond depth");
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(wr && full))
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        rd |-> rvalid)
        else $error("queue read while empty");
`endif

endmodule

@@ hw/rtl/tpc_back.sv @@
// Back end: format entry records and count reports into the output register.
module tpc_back (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  tpc_pkg::cfg_t                          cfg,
    input  logic                                   cmd_valid,
    input  tpc_pkg::cmd_t                          cmd,
    output logic                                   cmd_pop,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic                                   m_kind,
    output logic [tpc_pkg::SLOT_FIELD_BITS-1:0]    m_slot,
    output logic signed [tpc_pkg::SCOORD_BITS-1:0] m_coord_a,
    output logic signed [tpc_pkg::SCOORD_BITS-1:0] m_coord_b,
    output logic signed [tpc_pkg::FLOW_BITS-1:0]   m_out_u,
    output logic signed [tpc_pkg::FLOW_BITS-1:0]   m_out_v,
    output logic [tpc_pkg::LEVEL_BITS-1:0]         m_strength,
    output logic [tpc_pkg::COUNT_BITS-1:0]         m_total,
    output logic                                   m_last
);

    logic                                   m_valid_reg;
    logic                                   m_valid_next;
    logic                                   rep_pending_reg;
    logic                                   rep_pending_next;
    logic                                   m_kind_reg;
    logic [tpc_pkg::SLOT_FIELD_BITS-1:0]    m_slot_reg;
    logic [tpc_pkg::SCOORD_BITS-1:0]        m_coord_a_reg;
    logic [tpc_pkg::SCOORD_BITS-1:0]        m_coord_b_reg;
    logic [tpc_pkg::FLOW_BITS-1:0]          m_out_u_reg;
    logic [tpc_pkg::FLOW_BITS-1:0]          m_out_v_reg;
    logic [tpc_pkg::LEVEL_BITS-1:0]         m_strength_reg;
    logic [tpc_pkg::COUNT_BITS-1:0]         m_total_reg;
    logic                                   m_last_reg;
    logic                                   load;
    logic                                   do_rec;
    logic [tpc_pkg::SCOORD_BITS-1:0]        x_ext;
    logic [tpc_pkg::SCOORD_BITS-1:0]        y_ext;
    logic [tpc_pkg::SCOORD_BITS-1:0]        rec_a;
    logic [tpc_pkg::SCOORD_BITS-1:0]        rec_b;

    assign load    = !m_valid_reg || m_ready;
    assign do_rec  = cmd.rec && !rep_pending_reg;
    assign cmd_pop = load && cmd_valid && !(do_rec && cmd.rep);

    assign x_ext = tpc_pkg::SCOORD_BITS'(cmd.x);
    assign y_ext = tpc_pkg::SCOORD_BITS'(cmd.y);

    always_comb begin
        case (cfg.mode)
            tpc_pkg::MODE_CENTRED: begin
                rec_a = x_ext - tpc_pkg::SCOORD_BITS'(cfg.image_width >> 1);
                rec_b = tpc_pkg::SCOORD_BITS'(cfg.image_height >> 1) - y_ext;
            end
            default: begin
                rec_a = x_ext;
                rec_b = y_ext;
            end
        endcase
    end

    always_comb begin
        m_valid_next     = m_valid_reg;
        rep_pending_next = rep_pending_reg;
        if (load) begin
            m_valid_next = cmd_valid;
            if (cmd_valid) begin
                rep_pending_next = do_rec && cmd.rep;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load && cmd_valid) begin
            if (do_rec) begin
                m_kind_reg     <= tpc_pkg::KIND_ENTRY;
                m_slot_reg     <= cmd.slot;
                m_coord_a_reg  <= rec_a;
                m_coord_b_reg  <= rec_b;
                m_out_u_reg    <= (cfg.mode == tpc_pkg::MODE_FLOW) ? cmd.flow_u : '0;
                m_out_v_reg    <= (cfg.mode == tpc_pkg::MODE_FLOW) ? cmd.flow_v : '0;
                m_strength_reg <= (cfg.mode == tpc_pkg::MODE_HOUGH) ? cmd.level : '0;
                m_total_reg    <= '0;
                m_last_reg     <= !cmd.rep;
            end else begin
                m_kind_reg     <= tpc_pkg::KIND_COUNT;
                m_slot_reg     <= '0;
                m_coord_a_reg  <= '0;
                m_coord_b_reg  <= '0;
                m_out_u_reg    <= '0;
                m_out_v_reg    <= '0;
                m_strength_reg <= '0;
                m_total_reg    <= cmd.total;
                m_last_reg     <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg     <= 1'b0;
            rep_pending_reg <= 1'b0;
        end else begin
            m_valid_reg     <= m_valid_next;
            rep_pending_reg <= rep_pending_next;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_kind     = m_kind_reg;
    assign m_slot     = m_slot_reg;
    assign m_coord_a  = $signed(m_coord_a_reg);
    assign m_coord_b  = $signed(m_coord_b_reg);
    assign m_out_u    = $signed(m_out_u_reg);
    assign m_out_v    = $signed(m_out_v_reg);
    assign m_strength = m_strength_reg;
    assign m_total    = m_total_reg;
    assign m_last     = m_last_reg;

`ifndef SYNTHESIS
    a_pending_has_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        rep_pending_reg |-> (cmd_valid && cmd.rep))
        else $error("report pending without its command");
    a_report_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_kind_reg == tpc_pkg::KIND_COUNT) |-> m_last_reg)
        else $error("count report not marked last");
    a_pending_after_split: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && cmd_valid && do_rec && cmd.rep) |=> (rep_pending_reg && !m_last_reg))
        else $error("entry record with following report mishandled");
`endif

endmodule

@@ hw/rtl/threshold_pixel_compactor.sv @@
// Top level of the threshold pixel compactor: configuration registers and datapath.
//
//   channel  direction  handshake          contents
//   s_       in         s_valid/s_ready    one pixel: coordinates, level, flow, frame end
//   m_       out        m_valid/m_ready    entry record or frame count report
//   cfg_     in         cfg_we             register write, index and data
//
// One pixel is taken per cycle while s_ready is high; results are registered in the queue,
// then in the output register. A frame-end entry record goes out before the count report.
// A four-entry command queue sits between the classifier and the output formatter.
// s_ready drops only when that queue is full. Reset clears the count and all control.
module threshold_pixel_compactor (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     cfg_we,
    input  logic [tpc_pkg::CFG_ADDR_BITS-1:0]        cfg_index,
    input  logic [tpc_pkg::CFG_DATA_BITS-1:0]        cfg_wdata,
    input  logic                                     s_valid,
    output logic                                     s_ready,
    input  logic [tpc_pkg::COORD_BITS-1:0]           s_pixel_x,
    input  logic [tpc_pkg::COORD_BITS-1:0]           s_pixel_y,
    input  logic [tpc_pkg::LEVEL_BITS-1:0]           s_level,
    input  logic signed [tpc_pkg::FLOW_BITS-1:0]     s_flow_u,
    input  logic signed [tpc_pkg::FLOW_BITS-1:0]     s_flow_v,
    input  logic                                     s_frame_end,
    output logic                                     m_valid,
    input  logic                                     m_ready,
    output logic                                     m_kind,
    output logic [tpc_pkg::SLOT_FIELD_BITS-1:0]      m_slot,
    output logic signed [tpc_pkg::SCOORD_BITS-1:0]   m_coord_a,
    output logic signed [tpc_pkg::SCOORD_BITS-1:0]   m_coord_b,
    output logic signed [tpc_pkg::FLOW_BITS-1:0]     m_out_u,
    output logic signed [tpc_pkg::FLOW_BITS-1:0]     m_out_v,
    output logic [tpc_pkg::LEVEL_BITS-1:0]           m_strength,
    output logic [tpc_pkg::COUNT_BITS-1:0]           m_total,
    output logic                                     m_last
);

    tpc_pkg::cfg_t cfg_reg;
    logic          q_wr;
    logic          q_full;
    logic          q_rd;
    logic          q_rvalid;
    tpc_pkg::cmd_t q_wdata;
    tpc_pkg::cmd_t q_rdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mode         <= tpc_pkg::MODE_RAW;
            cfg_reg.threshold    <= tpc_pkg::THRESHOLD_RESET;
            cfg_reg.max_entries  <= tpc_pkg::MAX_ENTRIES_RESET;
            cfg_reg.image_width  <= tpc_pkg::IMAGE_WIDTH_RESET;
            cfg_reg.image_height <= tpc_pkg::IMAGE_HEIGHT_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                tpc_pkg::REG_MODE: begin
                    cfg_reg.mode <= tpc_pkg::mode_t'(cfg_wdata[tpc_pkg::MODE_BITS-1:0]);
                end
                tpc_pkg::REG_THRESHOLD: begin
                    cfg_reg.threshold <= cfg_wdata[tpc_pkg::LEVEL_BITS-1:0];
                end
                tpc_pkg::REG_MAX_ENTRIES: begin
                    cfg_reg.max_entries <= cfg_wdata[tpc_pkg::COUNT_BITS-1:0];
                end
                tpc_pkg::REG_IMAGE_WIDTH: begin
                    cfg_reg.image_width <= cfg_wdata[tpc_pkg::DIM_BITS-1:0];
                end
                tpc_pkg::REG_IMAGE_HEIGHT: begin
                    cfg_reg.image_height <= cfg_wdata[tpc_pkg::DIM_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    tpc_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_pixel_x   (s_pixel_x),
        .s_pixel_y   (s_pixel_y),
        .s_level     (s_level),
        .s_flow_u    (s_flow_u),
        .s_flow_v    (s_flow_v),
        .s_frame_end (s_frame_end),
        .cfg         (cfg_reg),
        .q_full      (q_full),
        .q_wr        (q_wr),
        .q_wdata     (q_wdata)
    );

    tpc_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (q_wr),
        .wdata   (q_wdata),
        .full    (q_full),
        .rd      (q_rd),
        .rvalid  (q_rvalid),
        .rdata   (q_rdata)
    );

    tpc_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .cmd_valid  (q_rvalid),
        .cmd        (q_rdata),
        .cmd_pop    (q_rd),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_kind     (m_kind),
        .m_slot     (m_slot),
        .m_coord_a  (m_coord_a),
        .m_coord_b  (m_coord_b),
        .m_out_u    (m_out_u),
        .m_out_v    (m_out_v),
        .m_strength (m_strength),
        .m_total    (m_total),
        .m_last     (m_last)
    );

endmodule
